/* rtl/core/srb_pkg.sv */
// Package for the sequence reorder buffer.
// Holds field widths, result status codes and job kinds shared by all modules but srb_ram.
// No dependencies.
package srb_pkg;

  localparam int unsigned CHAN_BITS   = 6;
  localparam int unsigned SEQ_BITS    = 32;
  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned COUNT_BITS  = 5;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_PASS    = 3'd0,
    ST_DELIVER = 3'd1,
    ST_PARK    = 3'd2,
    ST_DROP    = 3'd3,
    ST_ASSIGN  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    JOB_PASS = 2'd0,
    JOB_SEND = 2'd1,
    JOB_RECV = 2'd2
  } job_kind_e;

endpackage

/* rtl/core/srb_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module srb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/srb_front.sv */
// Front end of the sequence reorder buffer: accepts input transfers, classifies
// them and holds them in a two-entry queue for the back end. Uses srb_pkg.
module srb_front #(
  parameter int unsigned NUM_CHANNELS = 64,
  parameter int unsigned HANDLE_BITS  = 16,
  parameter int unsigned CW           = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     enable_i,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [srb_pkg::CHAN_BITS-1:0] chan_i,
  input  logic [srb_pkg::SEQ_BITS-1:0]  seq_i,
  input  logic [HANDLE_BITS-1:0]   handle_i,
  input  logic                     command_i,
  input  logic                     bypass_i,
  output logic                     q_valid_o,
  input  logic                     q_pop_i,
  output srb_pkg::job_kind_e       q_kind_o,
  output logic [CW-1:0]            q_chan_o,
  output logic [srb_pkg::SEQ_BITS-1:0] q_seq_o,
  output logic [HANDLE_BITS-1:0]   q_handle_o
);
  import srb_pkg::*;

  localparam int unsigned CHAN_VALUES = 2 ** CHAN_BITS;

  logic [CW-1:0]         chan_map [CHAN_VALUES];
  job_kind_e             kind_q   [2];
  logic [CW-1:0]         chan_q   [2];
  logic [SEQ_BITS-1:0]   seq_q    [2];
  logic [HANDLE_BITS-1:0] handle_q [2];
  logic                  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]            count_q, count_d;
  logic                  push;
  job_kind_e             kind_in;

  for (genvar i = 0; i < CHAN_VALUES; i++) begin : g_chan_map
    assign chan_map[i] = CW'(i % NUM_CHANNELS);
  end

  assign s_axis_tready_o = enable_i && (count_q != 2'd2);
  assign push            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    priority if (bypass_i) begin
      kind_in = JOB_PASS;
    end else if (command_i) begin
      kind_in = JOB_SEND;
    end else begin
      kind_in = JOB_RECV;
    end
  end

  always_comb begin
    wptr_d  = wptr_q ^ push;
    rptr_d  = rptr_q ^ q_pop_i;
    count_d = count_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wptr_q]   <= kind_in;
      chan_q[wptr_q]   <= chan_map[chan_i];
      seq_q[wptr_q]    <= seq_i;
      handle_q[wptr_q] <= handle_i;
    end
  end

  assign q_valid_o  = (count_q != 2'd0);
  assign q_kind_o   = kind_q[rptr_q];
  assign q_chan_o   = chan_q[rptr_q];
  assign q_seq_o    = seq_q[rptr_q];
  assign q_handle_o = handle_q[rptr_q];

endmodule

/* rtl/core/srb_back.sv */
// Back end of the sequence reorder buffer: channel state and parked-handle
// memories, the per-item sequencer, the drain loop and the output register.
// Uses srb_pkg and srb_ram.
module srb_back #(
  parameter int unsigned NUM_CHANNELS = 64,
  parameter int unsigned WINDOW       = 16,
  parameter int unsigned HANDLE_BITS  = 16,
  parameter int unsigned CW           = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  output logic                     ready_o,
  input  logic                     q_valid_i,
  output logic                     q_pop_o,
  input  srb_pkg::job_kind_e       q_kind_i,
  input  logic [CW-1:0]            q_chan_i,
  input  logic [srb_pkg::SEQ_BITS-1:0] q_seq_i,
  input  logic [HANDLE_BITS-1:0]   q_handle_i,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output srb_pkg::status_e         m_status_o,
  output logic [HANDLE_BITS-1:0]   m_handle_o,
  output logic [srb_pkg::SEQ_BITS-1:0] m_seq_o,
  output logic                     m_last_o
);
  import srb_pkg::*;

  localparam int unsigned SW       = $clog2(WINDOW);
  localparam int unsigned CSW      = 2 * SEQ_BITS + SW + WINDOW;
  localparam int unsigned SLOTS    = NUM_CHANNELS * WINDOW;
  localparam int unsigned AW       = $clog2(SLOTS);
  localparam int unsigned SUMW     = SW + 2;
  localparam longint unsigned WRAP_REM = 64'h1_0000_0000 % WINDOW;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_DRD   = 3'd4;
  localparam logic [2:0] S_DEMIT = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         clr_q, clr_d;
  logic [COUNT_BITS-1:0] k_q, k_d;
  logic                  more_q, more_d;
  logic                  m_valid_q, m_valid_d;

  job_kind_e             kind_q, kind_d;
  logic [CW-1:0]         ch_q, ch_d;
  logic [SEQ_BITS-1:0]   seq_q, seq_d;
  logic [HANDLE_BITS-1:0] hdl_q, hdl_d;
  logic [SEQ_BITS-1:0]   e_q, e_d, ns_q, ns_d;
  logic [SW-1:0]         emod_q, emod_d;
  logic [WINDOW-1:0]     row_q, row_d;
  status_e               res_st_q, res_st_d;
  logic [HANDLE_BITS-1:0] res_hdl_q, res_hdl_d;
  logic [SEQ_BITS-1:0]   res_seq_q, res_seq_d;
  status_e               out_st_q, out_st_d;
  logic [HANDLE_BITS-1:0] out_hdl_q, out_hdl_d;
  logic [SEQ_BITS-1:0]   out_seq_q, out_seq_d;
  logic                  out_last_q, out_last_d;

  logic                  chan_we;
  logic [CW-1:0]         chan_waddr;
  logic [CSW-1:0]        chan_wdata, chan_rdata;
  logic                  hdl_we;
  logic [AW-1:0]         hdl_waddr, hdl_raddr, ch_base;
  logic [HANDLE_BITS-1:0] hdl_rdata;

  logic [SEQ_BITS-1:0]   rd_e, rd_ns, diff;
  logic [SW-1:0]         rd_emod, slot;
  logic [WINDOW-1:0]     rd_row;
  logic                  wrap;
  logic [SUMW-1:0]       slot_sum;
  logic                  out_free;

  function automatic logic [SW-1:0] emod_next(logic [SEQ_BITS-1:0] e, logic [SW-1:0] m);
    logic [SW-1:0] r;
    if (e == '1) begin
      r = '0;
    end else if (m == SW'(WINDOW - 1)) begin
      r = '0;
    end else begin
      r = m + 1'b1;
    end
    return r;
  endfunction

  srb_ram #(.WIDTH(CSW), .DEPTH(NUM_CHANNELS)) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (chan_we),
    .waddr_i (chan_waddr),
    .wdata_i (chan_wdata),
    .raddr_i (q_chan_i),
    .rdata_o (chan_rdata)
  );

  srb_ram #(.WIDTH(HANDLE_BITS), .DEPTH(SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (hdl_we),
    .waddr_i (hdl_waddr),
    .wdata_i (hdl_q),
    .raddr_i (hdl_raddr),
    .rdata_o (hdl_rdata)
  );

  assign rd_e    = chan_rdata[SEQ_BITS-1:0];
  assign rd_emod = chan_rdata[SEQ_BITS +: SW];
  assign rd_ns   = chan_rdata[SEQ_BITS+SW +: SEQ_BITS];
  assign rd_row  = chan_rdata[2*SEQ_BITS+SW +: WINDOW];

  assign diff     = seq_q - rd_e;
  assign wrap     = (seq_q < rd_e);
  assign slot_sum = SUMW'(rd_emod) + SUMW'(diff[SW-1:0])
                  + (wrap ? SUMW'(WINDOW - WRAP_REM) : SUMW'(0));

  always_comb begin
    if (slot_sum >= SUMW'(2 * WINDOW)) begin
      slot = SW'(slot_sum - SUMW'(2 * WINDOW));
    end else if (slot_sum >= SUMW'(WINDOW)) begin
      slot = SW'(slot_sum - SUMW'(WINDOW));
    end else begin
      slot = SW'(slot_sum);
    end
  end

  assign ch_base   = AW'(ch_q) * AW'(WINDOW);
  assign hdl_waddr = ch_base + AW'(slot);
  assign hdl_raddr = ch_base + AW'(emod_q);
  assign out_free  = !m_valid_q || m_ready_i;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    k_d        = k_q;
    more_d     = more_q;
    m_valid_d  = m_valid_q && !m_ready_i;
    kind_d     = kind_q;
    ch_d       = ch_q;
    seq_d      = seq_q;
    hdl_d      = hdl_q;
    e_d        = e_q;
    emod_d     = emod_q;
    ns_d       = ns_q;
    row_d      = row_q;
    res_st_d   = res_st_q;
    res_hdl_d  = res_hdl_q;
    res_seq_d  = res_seq_q;
    out_st_d   = out_st_q;
    out_hdl_d  = out_hdl_q;
    out_seq_d  = out_seq_q;
    out_last_d = out_last_q;
    q_pop_o    = 1'b0;
    chan_we    = 1'b0;
    chan_waddr = ch_q;
    chan_wdata = {row_q, ns_q, emod_q, e_q};
    hdl_we     = 1'b0;

    unique case (state_q)
      S_INIT: begin
        chan_we    = 1'b1;
        chan_waddr = clr_q;
        chan_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == CW'(NUM_CHANNELS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          kind_d  = q_kind_i;
          ch_d    = q_chan_i;
          seq_d   = q_seq_i;
          hdl_d   = q_handle_i;
          state_d = S_READ;
        end
      end
      S_READ: begin
        e_d       = rd_e;
        emod_d    = rd_emod;
        ns_d      = rd_ns;
        row_d     = rd_row;
        k_d       = COUNT_BITS'(1);
        more_d    = 1'b0;
        res_hdl_d = hdl_q;
        res_seq_d = '0;
        unique case (kind_q)
          JOB_PASS: begin
            res_st_d = ST_PASS;
          end
          JOB_SEND: begin
            res_st_d  = ST_ASSIGN;
            res_seq_d = rd_ns;
            ns_d      = rd_ns + 1'b1;
          end
          JOB_RECV: begin
            if (diff == '0) begin
              row_d[rd_emod] = 1'b0;
              res_st_d       = ST_DELIVER;
              res_seq_d      = rd_e;
              e_d            = rd_e + 1'b1;
              emod_d         = emod_next(rd_e, rd_emod);
            end else if (diff < SEQ_BITS'(WINDOW)) begin
              if (rd_row[slot]) begin
                res_st_d = ST_DROP;
              end else begin
                row_d[slot] = 1'b1;
                hdl_we      = 1'b1;
                res_st_d    = ST_PARK;
              end
            end else begin
              res_st_d = ST_DROP;
            end
            more_d = row_d[emod_d];
          end
          default: begin
            res_st_d = ST_PASS;
          end
        endcase
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          out_st_d   = res_st_q;
          out_hdl_d  = res_hdl_q;
          out_seq_d  = res_seq_q;
          out_last_d = !more_q;
          if (more_q) begin
            state_d = S_DRD;
          end else begin
            chan_we = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_DRD: begin
        state_d = S_DEMIT;
      end
      S_DEMIT: begin
        res_st_d       = ST_DELIVER;
        res_hdl_d      = hdl_rdata;
        res_seq_d      = e_q;
        row_d[emod_q]  = 1'b0;
        e_d            = e_q + 1'b1;
        emod_d         = emod_next(e_q, emod_q);
        k_d            = k_q + 1'b1;
        more_d         = (k_d < COUNT_BITS'(MAX_RESULTS)) && row_d[emod_d];
        state_d        = S_EMIT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      clr_q     <= '0;
      k_q       <= '0;
      more_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      k_q       <= k_d;
      more_q    <= more_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    ch_q       <= ch_d;
    seq_q      <= seq_d;
    hdl_q      <= hdl_d;
    e_q        <= e_d;
    emod_q     <= emod_d;
    ns_q       <= ns_d;
    row_q      <= row_d;
    res_st_q   <= res_st_d;
    res_hdl_q  <= res_hdl_d;
    res_seq_q  <= res_seq_d;
    out_st_q   <= out_st_d;
    out_hdl_q  <= out_hdl_d;
    out_seq_q  <= out_seq_d;
    out_last_q <= out_last_d;
  end

  assign ready_o    = (state_q != S_INIT);
  assign m_valid_o  = m_valid_q;
  assign m_status_o = out_st_q;
  assign m_handle_o = out_hdl_q;
  assign m_seq_o    = out_seq_q;
  assign m_last_o   = out_last_q;

endmodule

/* rtl/core/sequence_reorder_buffer.sv */
// Top level of the per-channel sequence reorder buffer.
// Instantiates srb_front and srb_back and packs the stream buses; uses srb_pkg.
//
// Usage: the slave stream carries messages to number (send) or to put back in
// order (receive); bypass messages pass through unnumbered. The master stream
// carries one or more results per input transfer, tlast marking the final one.
// Each channel keeps an expected receive number and a next send number. A
// receive transfer that matches is delivered, then parked messages that follow
// in sequence are released, up to sixteen results per input. A receive that is
// ahead of expected but inside the window is parked; anything else is dropped.
// An item goes from the queue through the states S_IDLE, S_READ and S_EMIT to
// the output register; each released parked message passes through S_DRD and
// S_DEMIT (the read of the parked-handle memory), then S_EMIT for the result. The
// per-channel state memory has one read port, so items are worked one after another.
// After reset the block sweeps the channel state memory, one channel a cycle,
// with s_axis_tready_o low. A stalled receiver holds the output register and
// the work stops behind it; up to two further input transfers are taken into
// the queue meanwhile.
module sequence_reorder_buffer #(
  parameter int unsigned NUM_CHANNELS = 64,
  parameter int unsigned WINDOW       = 16,
  parameter int unsigned HANDLE_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // Fields from bit 0: channel, seq_number, msg_handle, zero fill.
  input  logic [((srb_pkg::CHAN_BITS + srb_pkg::SEQ_BITS + HANDLE_BITS + 7) / 8) * 8 - 1:0]
               s_axis_tdata_i,
  // Fields from bit 0: command, bypass.
  input  logic [1:0] s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // Fields from bit 0: handle_out, seq_out, zero fill.
  output logic [((srb_pkg::SEQ_BITS + HANDLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // Fields from bit 0: status.
  output logic [srb_pkg::STATUS_BITS-1:0] m_axis_tuser_o,
  output logic m_axis_tlast_o
);
  import srb_pkg::*;

  localparam int unsigned CW    = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned OUT_W = ((SEQ_BITS + HANDLE_BITS + 7) / 8) * 8;

  logic                   back_ready, q_valid, q_pop;
  job_kind_e              q_kind;
  logic [CW-1:0]          q_chan;
  logic [SEQ_BITS-1:0]    q_seq, m_seq;
  logic [HANDLE_BITS-1:0] q_handle, m_handle;
  status_e                m_status;

  srb_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .HANDLE_BITS  (HANDLE_BITS),
    .CW           (CW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .enable_i        (back_ready),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .chan_i          (s_axis_tdata_i[CHAN_BITS-1:0]),
    .seq_i           (s_axis_tdata_i[CHAN_BITS +: SEQ_BITS]),
    .handle_i        (s_axis_tdata_i[CHAN_BITS+SEQ_BITS +: HANDLE_BITS]),
    .command_i       (s_axis_tuser_i[0]),
    .bypass_i        (s_axis_tuser_i[1]),
    .q_valid_o       (q_valid),
    .q_pop_i         (q_pop),
    .q_kind_o        (q_kind),
    .q_chan_o        (q_chan),
    .q_seq_o         (q_seq),
    .q_handle_o      (q_handle)
  );

  srb_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .WINDOW       (WINDOW),
    .HANDLE_BITS  (HANDLE_BITS),
    .CW           (CW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ready_o    (back_ready),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_kind_i   (q_kind),
    .q_chan_i   (q_chan),
    .q_seq_i    (q_seq),
    .q_handle_i (q_handle),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_status_o (m_status),
    .m_handle_o (m_handle),
    .m_seq_o    (m_seq),
    .m_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OUT_W'({m_seq, m_handle});
  assign m_axis_tuser_o = m_status;

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the sequence reorder buffer.
// Predicts every result of each input transfer and compares them in order;
// uses srb_pkg and the sequence_reorder_buffer top level.
module tb_top;
  import srb_pkg::*;

  localparam int unsigned NCH = 64;
  localparam int unsigned WIN = 16;
  localparam int unsigned HB  = 16;
  localparam int unsigned SDW = ((CHAN_BITS + SEQ_BITS + HB + 7) / 8) * 8;
  localparam int unsigned MDW = ((SEQ_BITS + HB + 7) / 8) * 8;

  typedef struct packed {
    logic        command;
    logic [5:0]  channel;
    logic [31:0] seq_number;
    logic [15:0] msg_handle;
    logic        bypass;
  } msg_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] handle;
    logic [31:0] seq;
    logic        last;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [SDW-1:0] s_axis_tdata_i = '0;
  logic [1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [MDW-1:0] m_axis_tdata_o;
  logic [STATUS_BITS-1:0] m_axis_tuser_o;
  logic m_axis_tlast_o;

  sequence_reorder_buffer #(.NUM_CHANNELS(NCH), .WINDOW(WIN), .HANDLE_BITS(HB)) i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o, .m_axis_tlast_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  msg_t pending_msgs[$];
  res_t expected_results[$];
  logic [31:0] rx_expected[NCH];
  logic [31:0] tx_next[NCH];
  logic        parked_valid[NCH][WIN];
  logic [15:0] parked_handle[NCH][WIN];
  int errors = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_released = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  function automatic res_t mk(status_e st, logic [15:0] h, logic [31:0] s);
    res_t r;
    r.status = st;
    r.handle = h;
    r.seq = s;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_order(input msg_t m);
    res_t outs[$];
    int ch;
    logic [31:0] e;
    logic [31:0] d;
    int sl;
    ch = m.channel % NCH;
    if (m.bypass) begin
      outs.push_back(mk(ST_PASS, m.msg_handle, 32'd0));
    end else if (m.command) begin
      outs.push_back(mk(ST_ASSIGN, m.msg_handle, tx_next[ch]));
      tx_next[ch] = tx_next[ch] + 32'd1;
    end else begin
      e = rx_expected[ch];
      d = m.seq_number - e;
      if (d == 0) begin
        parked_valid[ch][e % WIN] = 1'b0;
        outs.push_back(mk(ST_DELIVER, m.msg_handle, e));
        rx_expected[ch] = e + 32'd1;
      end else if (d < WIN) begin
        sl = m.seq_number % WIN;
        if (parked_valid[ch][sl]) begin
          outs.push_back(mk(ST_DROP, m.msg_handle, 32'd0));
        end else begin
          parked_valid[ch][sl] = 1'b1;
          parked_handle[ch][sl] = m.msg_handle;
          outs.push_back(mk(ST_PARK, m.msg_handle, 32'd0));
        end
      end else begin
        outs.push_back(mk(ST_DROP, m.msg_handle, 32'd0));
      end
      while (outs.size() < MAX_RESULTS) begin
        e = rx_expected[ch];
        sl = e % WIN;
        if (!parked_valid[ch][sl]) break;
        parked_valid[ch][sl] = 1'b0;
        outs.push_back(mk(ST_DELIVER, parked_handle[ch][sl], e));
        rx_expected[ch] = e + 32'd1;
        n_released++;
      end
    end
    outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) expected_results.push_back(outs[i]);
  endtask

  function automatic msg_t mk_msg(int cmd, int ch, logic [31:0] s, int h, int byp);
    msg_t m;
    m.command = 1'(cmd);
    m.channel = 6'(ch);
    m.seq_number = s;
    m.msg_handle = 16'(h);
    m.bypass = 1'(byp);
    return m;
  endfunction

  int gap_left = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      predict_order(pending_msgs.pop_front());
      n_sent++;
    end
    if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      s_axis_tvalid_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0 &&
                 !(s_axis_tvalid_i && !s_axis_tready_o)) begin
      gap_left <= $urandom_range(0, 4);
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (pending_msgs.size() > 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= SDW'({pending_msgs[0].msg_handle, pending_msgs[0].seq_number,
                                pending_msgs[0].channel});
        s_axis_tuser_i <= {pending_msgs[0].bypass, pending_msgs[0].command};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    res_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      n_results++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d data=%h", $time, m_axis_tuser_o,
                 m_axis_tdata_o);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser_o !== want.status || m_axis_tdata_o[15:0] !== want.handle ||
            m_axis_tdata_o[47:16] !== want.seq || m_axis_tlast_o !== want.last) begin
          errors++;
          $display("%0t: mismatch expected st=%0d h=%h seq=%h last=%b %s",
                   $time, want.status, want.handle, want.seq, want.last,
                   $sformatf("got st=%0d h=%h seq=%h last=%b", m_axis_tuser_o,
                             m_axis_tdata_o[15:0], m_axis_tdata_o[47:16], m_axis_tlast_o));
        end
      end
    end
    if (hold_off) begin
      m_axis_tready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Queues a burst of receive messages on one channel, numbered base to base+len-1 in shuffled order.
  task automatic add_burst(input int ch, input logic [31:0] base, input int len);
    int order[$];
    int j;
    int t;
    for (int i = 0; i < len; i++) order.push_back(i);
    for (int i = len - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) pending_msgs.push_back(mk_msg(0, ch, base + order[i], $urandom, 0));
  endtask

  logic [31:0] gen_rx[NCH];

  initial begin
    int ch;
    int len;
    int r;
    foreach (rx_expected[i]) begin
      rx_expected[i] = '0;
      tx_next[i] = '0;
      gen_rx[i] = '0;
    end
    foreach (parked_valid[i, j]) parked_valid[i][j] = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_msgs.push_back(mk_msg(0, 0, 32'd0, 16'h0000, 1));
    pending_msgs.push_back(mk_msg(1, 63, 32'hFFFF_FFFF, 16'hFFFF, 1));
    pending_msgs.push_back(mk_msg(1, 0, 32'd0, 16'hFFFF, 0));
    pending_msgs.push_back(mk_msg(1, 0, 32'hFFFF_FFFF, 16'h0001, 0));
    pending_msgs.push_back(mk_msg(0, 63, 32'hFFFF_FFFF, 16'hAAAA, 0));
    pending_msgs.push_back(mk_msg(0, 63, 32'd16, 16'h5555, 0));
    pending_msgs.push_back(mk_msg(0, 63, 32'd15, 16'h1234, 0));
    pending_msgs.push_back(mk_msg(0, 63, 32'd15, 16'h4321, 0));
    pending_msgs.push_back(mk_msg(0, 63, 32'd1, 16'h1111, 0));
    pending_msgs.push_back(mk_msg(0, 63, 32'd0, 16'h0F0F, 0));
    pending_msgs.push_back(mk_msg(0, 63, 32'd0, 16'hF0F0, 0));
    for (int i = 16; i >= 1; i--) pending_msgs.push_back(mk_msg(0, 5, i, 16'h0500 + i, 0));
    pending_msgs.push_back(mk_msg(0, 5, 32'd0, 16'h0500, 0));
    pending_msgs.push_back(mk_msg(0, 5, 32'hFFFF_FFFF, 16'h05FF, 0));
    wait (pending_msgs.size() == 0);
    wait (expected_results.size() == 0);
    for (int i = 0; i < NCH; i++) gen_rx[i] = rx_expected[i];

    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) pending_msgs.push_back(mk_msg(1, i, $urandom, $urandom, 0));
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;

    while (pending_msgs.size() + n_sent < 340) begin
      r = $urandom_range(0, 9);
      ch = $urandom_range(0, 7) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 3);
      if (r < 6) begin
        len = $urandom_range(1, 18);
        add_burst(ch, gen_rx[ch], len);
        gen_rx[ch] = gen_rx[ch] + len;
      end else if (r < 8) begin
        pending_msgs.push_back(mk_msg($urandom_range(0, 1), ch, $urandom, $urandom,
                                      $urandom_range(0, 3) == 0));
      end else begin
        pending_msgs.push_back(mk_msg(0, ch, gen_rx[ch] + $urandom_range(0, 20) - 4,
                                      $urandom, 0));
      end
      if (pending_msgs.size() + n_sent > 290) quiet = 1'b1;
    end
    quiet = 1'b1;
    wait (pending_msgs.size() == 0);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d input transfers and %0d results, %0d released from parking.",
             n_sent, n_results, n_released);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
